// ===== sv/assert_macros.svh =====
// assertion macros for the ray triangle block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rti_pkg.sv =====
// shared constants and codes for the ray triangle intersection core
`timescale 1ns / 1ps
`default_nettype none
package rti_pkg;

    localparam int T_FRAC     = 16;
    localparam int DIST_BITS  = 32;
    localparam int LIMIT_BITS = 48;

    typedef enum logic [1:0] {
        CAUSE_HIT      = 2'd0,
        CAUSE_PARALLEL = 2'd1,
        CAUSE_BEHIND   = 2'd2,
        CAUSE_OUTSIDE  = 2'd3
    } cause_t;

endpackage
`default_nettype wire

// ===== sv/ray_triangle_intersect_core.sv =====
// ray triangle intersection core: plane distance and edge side tests, fully pipelined
// done strobes after stages 1 to 5, the 32 step divider and stages p, q, d, a and b
// throughput: one item per cycle, busy stays low and results cannot be held off
// each divider stage settles one quotient bit with a wide compare and subtract
// reset clears all stage valid bits and sets the parallel limit to zero
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ray_triangle_intersect_core #(
    parameter int COORD_BITS = 20
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic signed [COORD_BITS-1:0]    origin_x,
    input  wire logic signed [COORD_BITS-1:0]    origin_y,
    input  wire logic signed [COORD_BITS-1:0]    origin_z,
    input  wire logic signed [COORD_BITS-1:0]    dir_x,
    input  wire logic signed [COORD_BITS-1:0]    dir_y,
    input  wire logic signed [COORD_BITS-1:0]    dir_z,
    input  wire logic [3*COORD_BITS-1:0]         vertex_a,
    input  wire logic [3*COORD_BITS-1:0]         vertex_b,
    input  wire logic [3*COORD_BITS-1:0]         vertex_c,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rti_pkg::LIMIT_BITS-1:0]  cfg_data,
    output logic                                 done,
    output logic                                 hit,
    output logic [rti_pkg::DIST_BITS-1:0]        distance,
    output logic [1:0]                           miss_cause
);
    import rti_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int D1   = C + 1;
    localparam int NW   = 2 * C + 3;
    localparam int PDW  = NW + C;
    localparam int PNW  = NW + D1;
    localparam int DENW = 3 * C + 5;
    localparam int NUMW = 3 * C + 6;
    localparam int MW   = 3 * C + 5;
    localparam int ADW  = DENW;
    localparam int ANW  = NUMW;
    localparam int CMPW = (ADW > LIMIT_BITS) ? ADW : LIMIT_BITS;
    localparam int OVW  = ADW + T_FRAC;
    localparam int STEPS = DIST_BITS;
    localparam int PRW  = C + DIST_BITS + 1;
    localparam int QW   = PRW - T_FRAC + 1;
    localparam int DW   = QW + 1;
    localparam int PLW  = DW + DIST_BITS + 1;
    localparam int PHW  = DW + MW - DIST_BITS;
    localparam int AXW  = DW + MW + 1;
    localparam int TW   = DW + MW + 3;
    localparam int LATENCY = 44;

    typedef logic signed [C-1:0]    crd_t;
    typedef crd_t [2:0]             cvec_t;
    typedef logic signed [D1-1:0]   dif_t;
    typedef dif_t [2:0]             dvec_t;
    typedef logic signed [NW-1:0]   nel_t;
    typedef nel_t [2:0]             nvec_t;
    typedef logic signed [PDW-1:0]  pden_t;
    typedef logic signed [PNW-1:0]  pnum_t;
    typedef logic signed [MW-1:0]   mel_t;
    typedef mel_t [2:0]             mvec_t;
    typedef logic signed [PRW-1:0]  prod_t;
    typedef logic signed [QW-1:0]   qel_t;
    typedef logic signed [DW-1:0]   del_t;
    typedef logic signed [PLW-1:0]  plo_t;
    typedef logic signed [PHW-1:0]  phi_t;
    typedef logic signed [AXW-1:0]  axl_t;

    typedef struct packed {
        cvec_t o;
        cvec_t dir;
        cvec_t va;
        cvec_t vb;
        cvec_t vc;
    } geo_t;

    typedef struct packed {
        geo_t           g;
        mvec_t [2:0]    m;
        logic           par;
        logic           beh;
        logic           ovf;
    } car_t;

    // configuration
    logic [LIMIT_BITS-1:0] lim_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // stage valids
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    logic sp_v_reg, sq_v_reg, sd_v_reg, sa_v_reg, sb_v_reg, done_reg;
    logic dv_v_reg [STEPS+1];

    // stage 1: edges and offsets
    geo_t           s1_g_reg, s1_g_next;
    dvec_t          s1_e1_reg, s1_e1_next, s1_e2_reg, s1_e2_next, s1_w_reg, s1_w_next;
    dvec_t [2:0]    s1_eg_reg, s1_eg_next;

    always_comb
    begin
        s1_g_next.o   = {origin_z, origin_y, origin_x};
        s1_g_next.dir = {dir_z, dir_y, dir_x};
        for (int k = 0; k < 3; k++)
        begin
            s1_g_next.va[k] = $signed(vertex_a[k*C +: C]);
            s1_g_next.vb[k] = $signed(vertex_b[k*C +: C]);
            s1_g_next.vc[k] = $signed(vertex_c[k*C +: C]);
        end
        for (int k = 0; k < 3; k++)
        begin
            s1_e1_next[k]    = D1'(s1_g_next.vb[k]) - D1'(s1_g_next.va[k]);
            s1_e2_next[k]    = D1'(s1_g_next.vc[k]) - D1'(s1_g_next.va[k]);
            s1_w_next[k]     = D1'(s1_g_next.va[k]) - D1'(s1_g_next.o[k]);
            s1_eg_next[0][k] = D1'(s1_g_next.vb[k]) - D1'(s1_g_next.va[k]);
            s1_eg_next[1][k] = D1'(s1_g_next.vc[k]) - D1'(s1_g_next.vb[k]);
            s1_eg_next[2][k] = D1'(s1_g_next.va[k]) - D1'(s1_g_next.vc[k]);
        end
    end

    // stage 2: plane normal
    geo_t           s2_g_reg;
    nvec_t          s2_n_reg, s2_n_next;
    dvec_t          s2_w_reg;
    dvec_t [2:0]    s2_eg_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            s2_n_next[a] = NW'(s1_e1_reg[(a == 2) ? 0 : a + 1] * s1_e2_reg[(a == 0) ? 2 : a - 1])
                         - NW'(s1_e1_reg[(a == 0) ? 2 : a - 1] * s1_e2_reg[(a == 2) ? 0 : a + 1]);
        end
    end

    // stage 3: partial products for denominator, numerator and edge normals
    geo_t                   s3_g_reg;
    pden_t [2:0]            s3_pden_reg, s3_pden_next;
    pnum_t [2:0]            s3_pnum_reg, s3_pnum_next;
    pnum_t [2:0][2:0][1:0]  s3_pm_reg, s3_pm_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s3_pden_next[k] = s2_n_reg[k] * s2_g_reg.dir[k];
            s3_pnum_next[k] = s2_n_reg[k] * s2_w_reg[k];
        end
        // n x edge, so the edge test becomes (q - v) . (n x edge)
        for (int e = 0; e < 3; e++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                s3_pm_next[e][a][0] = s2_n_reg[(a == 2) ? 0 : a + 1]
                                    * s2_eg_reg[e][(a == 0) ? 2 : a - 1];
                s3_pm_next[e][a][1] = s2_n_reg[(a == 0) ? 2 : a - 1]
                                    * s2_eg_reg[e][(a == 2) ? 0 : a + 1];
            end
        end
    end

    // stage 4: sums
    geo_t                       s4_g_reg;
    logic signed [DENW-1:0]     s4_den_reg, s4_den_next;
    logic signed [NUMW-1:0]     s4_num_reg, s4_num_next;
    mvec_t [2:0]                s4_m_reg, s4_m_next;

    always_comb
    begin
        s4_den_next = DENW'(s3_pden_reg[0]) + DENW'(s3_pden_reg[1]) + DENW'(s3_pden_reg[2]);
        s4_num_next = NUMW'(s3_pnum_reg[0]) + NUMW'(s3_pnum_reg[1]) + NUMW'(s3_pnum_reg[2]);
        for (int e = 0; e < 3; e++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                s4_m_next[e][a] = MW'(s3_pm_reg[e][a][0]) - MW'(s3_pm_reg[e][a][1]);
            end
        end
    end

    // stage 5: magnitudes
    geo_t               s5_g_reg;
    mvec_t [2:0]        s5_m_reg;
    logic [ADW-1:0]     s5_aden_reg, s5_aden_next;
    logic [ANW-1:0]     s5_anum_reg, s5_anum_next;
    logic               s5_beh_reg, s5_beh_next;

    always_comb
    begin
        s5_aden_next = s4_den_reg[DENW-1] ? ADW'(-s4_den_reg) : ADW'(s4_den_reg);
        s5_anum_next = s4_num_reg[NUMW-1] ? ANW'(-s4_num_reg) : ANW'(s4_num_reg);
        s5_beh_next  = (s4_num_reg != '0) && (s4_num_reg[NUMW-1] != s4_den_reg[DENW-1]);
    end

    // divider, entry 0 is loaded from stage 5
    logic [ADW-1:0]         dv_r_reg [STEPS+1];
    logic [ADW-1:0]         dv_d_reg [STEPS+1];
    logic [DIST_BITS-1:0]   dv_q_reg [STEPS+1];
    logic [DIST_BITS-1:0]   dv_n_reg [STEPS+1];
    car_t                   dv_c_reg [STEPS+1];
    car_t                   dv0_c_next;

    always_comb
    begin
        dv0_c_next.g   = s5_g_reg;
        dv0_c_next.m   = s5_m_reg;
        dv0_c_next.par = CMPW'(s5_aden_reg) <= CMPW'(lim_reg);
        dv0_c_next.beh = s5_beh_reg;
        // quotient would not fit in the distance field
        dv0_c_next.ovf = OVW'(s5_anum_reg) >= {s5_aden_reg, {T_FRAC{1'b0}}};
    end

    genvar gk;
    generate
        for (gk = 0; gk < STEPS; gk++)
        begin : g_div
            logic [ADW:0]   rs;
            logic [ADW:0]   df;
            logic           ge;

            always_comb
            begin
                rs = {dv_r_reg[gk], dv_n_reg[gk][DIST_BITS-1]};
                df = rs - {1'b0, dv_d_reg[gk]};
                ge = rs >= {1'b0, dv_d_reg[gk]};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_v_reg[gk+1] <= 1'b0;
                end
                else
                begin
                    dv_v_reg[gk+1] <= dv_v_reg[gk];
                end
            end

            always_ff @(posedge clk)
            begin
                dv_r_reg[gk+1] <= ge ? df[ADW-1:0] : rs[ADW-1:0];
                dv_d_reg[gk+1] <= dv_d_reg[gk];
                dv_q_reg[gk+1] <= {dv_q_reg[gk][DIST_BITS-2:0], ge};
                dv_n_reg[gk+1] <= {dv_n_reg[gk][DIST_BITS-2:0], 1'b0};
                dv_c_reg[gk+1] <= dv_c_reg[gk];
            end
        end
    endgenerate

    // stage p: saturate t and scale the direction
    car_t                   sp_c_reg;
    logic [DIST_BITS-1:0]   sp_t_reg, sp_t_next;
    prod_t [2:0]            sp_pr_reg, sp_pr_next;

    always_comb
    begin
        sp_t_next = dv_c_reg[STEPS].ovf ? '1 : dv_q_reg[STEPS];
        for (int k = 0; k < 3; k++)
        begin
            sp_pr_next[k] = dv_c_reg[STEPS].g.dir[k] * $signed({1'b0, sp_t_next});
        end
    end

    // stage q: hit point, floor by arithmetic shift
    car_t                   sq_c_reg;
    logic [DIST_BITS-1:0]   sq_t_reg;
    qel_t [2:0]             sq_q_reg, sq_q_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq_q_next[k] = QW'(sp_c_reg.g.o[k]) + QW'($signed(sp_pr_reg[k][PRW-1:T_FRAC]));
        end
    end

    // stage d: hit point relative to each edge start
    car_t                   sd_c_reg;
    logic [DIST_BITS-1:0]   sd_t_reg;
    del_t [2:0][2:0]        sd_d_reg, sd_d_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sd_d_next[0][k] = DW'(sq_q_reg[k]) - DW'(sq_c_reg.g.va[k]);
            sd_d_next[1][k] = DW'(sq_q_reg[k]) - DW'(sq_c_reg.g.vb[k]);
            sd_d_next[2][k] = DW'(sq_q_reg[k]) - DW'(sq_c_reg.g.vc[k]);
        end
    end

    // stage a: split products, edge normal cut into low and high words
    logic                   sa_par_reg, sa_beh_reg;
    logic [DIST_BITS-1:0]   sa_t_reg;
    plo_t [2:0][2:0]        sa_lo_reg, sa_lo_next;
    phi_t [2:0][2:0]        sa_hi_reg, sa_hi_next;

    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sa_lo_next[e][k] = sd_d_reg[e][k]
                                 * $signed({1'b0, sd_c_reg.m[e][k][DIST_BITS-1:0]});
                sa_hi_next[e][k] = sd_d_reg[e][k]
                                 * $signed(sd_c_reg.m[e][k][MW-1:DIST_BITS]);
            end
        end
    end

    // stage b: per axis terms
    logic                   sb_par_reg, sb_beh_reg;
    logic [DIST_BITS-1:0]   sb_t_reg;
    axl_t [2:0][2:0]        sb_ax_reg, sb_ax_next;

    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sb_ax_next[e][k] = (AXW'(sa_hi_reg[e][k]) <<< DIST_BITS) + AXW'(sa_lo_reg[e][k]);
            end
        end
    end

    // output stage: edge signs and outcome
    logic signed [TW-1:0]   side [3];
    logic [2:0]             inside_edges;
    cause_t                 cause_next;
    cause_t                 cause_reg;
    logic [DIST_BITS-1:0]   dist_reg;

    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            side[e] = TW'(sb_ax_reg[e][0]) + TW'(sb_ax_reg[e][1]) + TW'(sb_ax_reg[e][2]);
            inside_edges[e] = !side[e][TW-1];
        end
        if (sb_par_reg)
        begin
            cause_next = CAUSE_PARALLEL;
        end
        else if (sb_beh_reg)
        begin
            cause_next = CAUSE_BEHIND;
        end
        else if (&inside_edges)
        begin
            cause_next = CAUSE_HIT;
        end
        else
        begin
            cause_next = CAUSE_OUTSIDE;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg     <= '0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            s4_v_reg    <= 1'b0;
            s5_v_reg    <= 1'b0;
            dv_v_reg[0] <= 1'b0;
            sp_v_reg    <= 1'b0;
            sq_v_reg    <= 1'b0;
            sd_v_reg    <= 1'b0;
            sa_v_reg    <= 1'b0;
            sb_v_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                lim_reg <= cfg_data;
            end
            s1_v_reg    <= start && !busy;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
            s4_v_reg    <= s3_v_reg;
            s5_v_reg    <= s4_v_reg;
            dv_v_reg[0] <= s5_v_reg;
            sp_v_reg    <= dv_v_reg[STEPS];
            sq_v_reg    <= sp_v_reg;
            sd_v_reg    <= sq_v_reg;
            sa_v_reg    <= sd_v_reg;
            sb_v_reg    <= sa_v_reg;
            done_reg    <= sb_v_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        s1_g_reg     <= s1_g_next;
        s1_e1_reg    <= s1_e1_next;
        s1_e2_reg    <= s1_e2_next;
        s1_w_reg     <= s1_w_next;
        s1_eg_reg    <= s1_eg_next;

        s2_g_reg     <= s1_g_reg;
        s2_n_reg     <= s2_n_next;
        s2_w_reg     <= s1_w_reg;
        s2_eg_reg    <= s1_eg_reg;

        s3_g_reg     <= s2_g_reg;
        s3_pden_reg  <= s3_pden_next;
        s3_pnum_reg  <= s3_pnum_next;
        s3_pm_reg    <= s3_pm_next;

        s4_g_reg     <= s3_g_reg;
        s4_den_reg   <= s4_den_next;
        s4_num_reg   <= s4_num_next;
        s4_m_reg     <= s4_m_next;

        s5_g_reg     <= s4_g_reg;
        s5_m_reg     <= s4_m_reg;
        s5_aden_reg  <= s5_aden_next;
        s5_anum_reg  <= s5_anum_next;
        s5_beh_reg   <= s5_beh_next;

        dv_r_reg[0]  <= ADW'(s5_anum_reg >> T_FRAC);
        dv_d_reg[0]  <= s5_aden_reg;
        dv_q_reg[0]  <= '0;
        dv_n_reg[0]  <= {s5_anum_reg[T_FRAC-1:0], {T_FRAC{1'b0}}};
        dv_c_reg[0]  <= dv0_c_next;

        sp_c_reg     <= dv_c_reg[STEPS];
        sp_t_reg     <= sp_t_next;
        sp_pr_reg    <= sp_pr_next;

        sq_c_reg     <= sp_c_reg;
        sq_t_reg     <= sp_t_reg;
        sq_q_reg     <= sq_q_next;

        sd_c_reg     <= sq_c_reg;
        sd_t_reg     <= sq_t_reg;
        sd_d_reg     <= sd_d_next;

        sa_par_reg   <= sd_c_reg.par;
        sa_beh_reg   <= sd_c_reg.beh;
        sa_t_reg     <= sd_t_reg;
        sa_lo_reg    <= sa_lo_next;
        sa_hi_reg    <= sa_hi_next;

        sb_par_reg   <= sa_par_reg;
        sb_beh_reg   <= sa_beh_reg;
        sb_t_reg     <= sa_t_reg;
        sb_ax_reg    <= sb_ax_next;

        cause_reg    <= cause_next;
        dist_reg     <= (cause_next == CAUSE_HIT) ? sb_t_reg : '0;
    end

    assign done       = done_reg;
    assign hit        = (cause_reg == CAUSE_HIT);
    assign distance   = dist_reg;
    assign miss_cause = cause_reg;

    `ASSERT_CLK(a_latency, (start && !busy) |-> ##LATENCY done, "item result did not appear on time")
    `ASSERT_CLK(a_miss_zero, (done && !hit) |-> (distance == '0), "miss carries a distance")
    `ASSERT_NEXT(a_div_valid, dv_v_reg[STEPS], sp_v_reg, "divider output valid lost")

endmodule
`default_nettype wire
